// ----- hdl/mmcrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcrc_pkg
// Shared types, constants and byte-wide fold functions of the check engine.
// ----------------------------------------------------------------------------
package mmcrc_pkg;

  typedef enum logic [2:0] {
    MODE_MODBUS   = 3'd0,
    MODE_XMODEM   = 3'd1,
    MODE_ITU      = 3'd2,
    MODE_CRC32    = 3'd3,
    MODE_CRC32INV = 3'd4,
    MODE_CRC8     = 3'd5,
    MODE_SUM8     = 3'd6,
    MODE_SUM16    = 3'd7
  } check_mode_t;

  localparam logic [15:0] POLY16_REFL = 16'hA001;
  localparam logic [15:0] POLY16_MSB  = 16'h1021;
  localparam logic [31:0] POLY32      = 32'h04C11DB7;
  localparam logic [7:0]  POLY8       = 8'h31;
  localparam logic [15:0] INIT16_ONES = 16'hFFFF;
  localparam logic [31:0] INIT32_ONES = 32'hFFFFFFFF;
  localparam logic [31:0] XOROUT32    = 32'hFFFFFFFF;

  function automatic logic [15:0] crc16_refl(input logic [15:0] v, input logic [7:0] b);
    logic [15:0] c;
    c = v ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ POLY16_REFL) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_msb(input logic [15:0] v, input logic [7:0] b);
    logic [15:0] c;
    c = v ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ POLY16_MSB) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [31:0] crc32_msb(input logic [31:0] v, input logic [7:0] b);
    logic [31:0] c;
    c = v ^ {b, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ POLY32) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] crc8_msb(input logic [7:0] v, input logic [7:0] b);
    logic [7:0] c;
    c = v ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ POLY8) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [15:0] sum16_eac(input logic [15:0] v, input logic [7:0] b);
    logic [16:0] s;
    s = {1'b0, v} + {9'h000, b};
    // end-around carry, cannot overflow a second time
    return s[16] ? (s[15:0] + 16'd1) : s[15:0];
  endfunction

endpackage

// ----- hdl/mmcrc_fold.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcrc_fold
// Folds one byte into the running check value for the selected mode.
// ----------------------------------------------------------------------------
module mmcrc_fold (
  input  mmcrc_pkg::check_mode_t mode,
  input  logic [31:0]            running,
  input  logic [7:0]             data_byte,
  input  logic                   first_byte,
  output logic [31:0]            running_nxt,
  output logic [31:0]            check_value
);
  import mmcrc_pkg::*;

  logic [31:0] seed;

  always_comb begin
    case (mode)
      MODE_MODBUS, MODE_ITU:      seed = first_byte ? {16'h0000, INIT16_ONES} : running;
      MODE_CRC32, MODE_CRC32INV:  seed = first_byte ? INIT32_ONES : running;
      default:                    seed = first_byte ? 32'h00000000 : running;
    endcase
  end

  always_comb begin
    case (mode)
      MODE_MODBUS:               running_nxt = {16'h0000, crc16_refl(seed[15:0], data_byte)};
      MODE_XMODEM, MODE_ITU:     running_nxt = {16'h0000, crc16_msb(seed[15:0], data_byte)};
      MODE_CRC32, MODE_CRC32INV: running_nxt = crc32_msb(seed, data_byte);
      MODE_CRC8:                 running_nxt = {24'h000000, crc8_msb(seed[7:0], data_byte)};
      MODE_SUM8:                 running_nxt = {24'h000000, seed[7:0] + data_byte};
      MODE_SUM16:                running_nxt = {16'h0000, sum16_eac(seed[15:0], data_byte)};
      default:                   running_nxt = seed;
    endcase
  end

  // running value of the inverted crc32 mode stays uninverted
  assign check_value = (mode == MODE_CRC32INV) ? (running_nxt ^ XOROUT32) : running_nxt;

endmodule

// ----- hdl/mmcrc_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcrc_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module mmcrc_out_reg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [31:0] load_value,
  output logic        free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_check_value
);
  import mmcrc_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  logic [31:0] value_r;

  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= load_value;
    end
  end

  assign out_valid       = valid_r;
  assign out_check_value = value_r;

endmodule

// ----- hdl/multi_mode_crc_checksum_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_mode_crc_checksum_top
// Byte-serial CRC-16/CRC-32/CRC-8 and checksum engine, one byte per clock while the input is not stalled.
// ----------------------------------------------------------------------------
// Each accepted byte is captured in an input register and folded into the
// running value by an eight-bit unrolled update; a byte flagged last writes
// its finished check into the result register, so a result passes through
// the input register and then the result register. Throughput is one byte
// per cycle while the input is not stalled. The input register keeps taking
// bytes while a result waits, and only a last byte meeting a stalled full
// result register holds the input. check_mode is taken through
// cfg_valid/cfg_ready and must only be changed while no byte is in flight; an
// open message continues in the new mode from the low bits of the running
// value.
module multi_mode_crc_checksum_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_check_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_check_mode
);
  import mmcrc_pkg::*;

  check_mode_t mode_r;
  logic        s1_valid_r;
  logic [7:0]  s1_data_r;
  logic        s1_first_r;
  logic        s1_last_r;
  logic [31:0] running_r;
  logic [31:0] running_nxt;
  logic [31:0] check_value;
  logic        out_free;
  logic        s1_go;
  logic        in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MODBUS;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= check_mode_t'(cfg_check_mode);
    end
  end

  // non-last bytes never need the result slot
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r  <= in_data_byte;
      s1_first_r <= in_first_byte;
      s1_last_r  <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 32'h00000000;
    end else if (s1_go) begin
      running_r <= running_nxt;
    end
  end

  mmcrc_fold u_fold (
    .mode        (mode_r),
    .running     (running_r),
    .data_byte   (s1_data_r),
    .first_byte  (s1_first_r),
    .running_nxt (running_nxt),
    .check_value (check_value)
  );

  mmcrc_out_reg u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (s1_go && s1_last_r),
    .load_value      (check_value),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_check_value (out_check_value)
  );

endmodule

// ----- hdl/mmcrc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcrc_assertions
// Port-level assertions for the check engine, bound to the top level.
// ----------------------------------------------------------------------------
module mmcrc_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_check_value,
  input logic        cfg_ready
);
  import mmcrc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_check_value))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with an empty result register the input side never holds
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with free result register");

  // input only stalls while a result is being held back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config request refused");

endmodule

bind multi_mode_crc_checksum_top mmcrc_assertions u_mmcrc_assertions (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_check_value (out_check_value),
  .cfg_ready       (cfg_ready)
);

// ----- bench/mmcrc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcrc_checker
// Watches the byte, result and mode channels of the check engine, folds every
// accepted byte into its own running CRC or sum and compares each finished
// check value with the oldest one it has predicted.
// ----------------------------------------------------------------------------
module mmcrc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_check_value,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_check_mode,
  output int          mismatch_count,
  output int          checks_in_flight
);
  import mmcrc_pkg::*;

  localparam logic [31:0] MODBUS_POLY = 32'h0000_A001;
  localparam logic [31:0] CCITT_POLY  = 32'h0000_1021;
  localparam logic [31:0] ETH_POLY    = 32'h04C1_1DB7;
  localparam logic [31:0] DOW_POLY    = 32'h0000_0031;

  check_mode_t   cur_mode;
  logic [31:0]   crc_state;
  logic [31:0]   pending_checks[$];
  int            errs;

  function automatic logic [31:0] seed_for(input check_mode_t m);
    case (m)
      MODE_MODBUS, MODE_ITU:     return 32'h0000_FFFF;
      MODE_CRC32, MODE_CRC32INV: return 32'hFFFF_FFFF;
      default:                   return 32'h0000_0000;
    endcase
  endfunction

  // fold one byte at the width of the mode; bits above that width are dropped
  function automatic logic [31:0] fold_check(input check_mode_t m, input logic [31:0] acc,
                                             input logic [7:0] b);
    logic [31:0] r;
    logic [16:0] s;
    int          k;
    r = 32'h0;
    case (m)
      MODE_MODBUS: begin
        r = {16'h0, acc[15:0] ^ {8'h00, b}};
        for (k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ MODBUS_POLY) : (r >> 1);
        r[31:16] = 16'h0;
      end
      MODE_XMODEM, MODE_ITU: begin
        r = {16'h0, acc[15:0] ^ {b, 8'h00}};
        for (k = 0; k < 8; k++) r = r[15] ? ((r << 1) ^ CCITT_POLY) : (r << 1);
        r[31:16] = 16'h0;
      end
      MODE_CRC32, MODE_CRC32INV: begin
        r = acc ^ {b, 24'h0};
        for (k = 0; k < 8; k++) r = r[31] ? ((r << 1) ^ ETH_POLY) : (r << 1);
      end
      MODE_CRC8: begin
        r = {24'h0, acc[7:0] ^ b};
        for (k = 0; k < 8; k++) r = r[7] ? ((r << 1) ^ DOW_POLY) : (r << 1);
        r[31:8] = 24'h0;
      end
      MODE_SUM8: begin
        r = {24'h0, acc[7:0] + b};
      end
      default: begin
        s = {1'b0, acc[15:0]} + {9'h0, b};
        r = {16'h0, s[16] ? (s[15:0] + 16'd1) : s[15:0]};
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    logic [31:0] acc;
    logic [31:0] want;
    if (!rst_n) begin
      cur_mode  = MODE_MODBUS;
      crc_state = 32'h0;
      pending_checks.delete();
      errs      = 0;
    end else begin
      if (cfg_valid && cfg_ready) cur_mode = check_mode_t'(cfg_check_mode);

      // results always trail their last byte, so compare before queuing new ones
      if (out_valid && !out_stall) begin
        if (pending_checks.size() == 0) begin
          $error("check_value: no result expected, got %08h", out_check_value);
          errs++;
        end else begin
          want = pending_checks.pop_front();
          if (out_check_value !== want) begin
            $error("check_value mismatch: expected %08h, got %08h", want, out_check_value);
            errs++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        acc       = in_first_byte ? seed_for(cur_mode) : crc_state;
        crc_state = fold_check(cur_mode, acc, in_data_byte);
        if (in_last_byte)
          pending_checks.push_back(cur_mode == MODE_CRC32INV ? ~crc_state : crc_state);
      end
    end
    mismatch_count   <= errs;
    checks_in_flight <= pending_checks.size();
  end

endmodule

// ----- bench/tb_multi_mode_crc_checksum_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_mode_crc_checksum_top
// Drives byte messages through the check engine in every mode, first with a
// few hand-picked cases, then random messages under several idle and stall
// patterns; the checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_multi_mode_crc_checksum_top;
  import mmcrc_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int PHASE_ITEMS   = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_first_byte = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_check_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_check_mode = 3'd0;

  int mismatch_count;
  int checks_in_flight;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent_items = 0;
  int cycle_count = 0;

  always #1 clk = ~clk;

  multi_mode_crc_checksum_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_first_byte   (in_first_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_check_value (out_check_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_check_mode  (cfg_check_mode)
  );

  mmcrc_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_first_byte    (in_first_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_check_value  (out_check_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_check_mode   (cfg_check_mode),
    .mismatch_count   (mismatch_count),
    .checks_in_flight (checks_in_flight)
  );

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_multi_mode_crc_checksum_top: done, errors");
      $finish;
    end
  end

  // valid stays high after acceptance until the next request or a gap replaces it
  task automatic push_byte(input logic [7:0] d, input logic f, input logic l);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= d;
    in_first_byte <= f;
    in_last_byte  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (checks_in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input check_mode_t m);
    settle();
    cfg_valid      <= 1'b1;
    cfg_check_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_message(input int len, input logic [7:0] lo, input logic with_first,
                              input logic with_last, input logic noisy);
    logic f;
    logic l;
    for (int i = 0; i < len; i++) begin
      f = with_first && (i == 0);
      l = with_last && (i == len - 1);
      // stray flags: restarts and early ends inside a message
      if (noisy && $urandom_range(19) == 0) begin
        f = 1'($urandom_range(1));
        l = 1'($urandom_range(1));
      end
      push_byte(8'($urandom_range(255, lo)), f, l);
    end
  endtask

  initial begin
    check_mode_t phase_mode;
    int          phase_start;
    int          len;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing loaded yet, folding starts from zero
    push_byte(8'hA5, 1'b0, 1'b1);
    push_byte(8'h00, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);
    for (int m = 1; m < 8; m++) begin
      set_mode(check_mode_t'(m));
      push_byte(8'h00, 1'b1, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b1);
    end
    // crc-32 leaves ff00 in its low half, sum16 carries on from there and wraps
    set_mode(MODE_CRC32);
    push_byte(8'hFF, 1'b1, 1'b0);
    set_mode(MODE_SUM16);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h01, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);

    for (int p = 0; p < 16; p++) begin
      phase_mode = check_mode_t'((p * 3) % 8);
      set_mode(phase_mode);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      phase_start = sent_items;
      // long high-valued message usually drives sum16 past its end-around carry
      if (p < 8 && phase_mode == MODE_SUM16) send_message(300, 8'd200, 1'b1, 1'b1, 1'b0);
      while (sent_items - phase_start < PHASE_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        send_message(len, 8'd0, $urandom_range(9) != 0, 1'b1, 1'b1);
      end
      // an open message carries over the next mode change
      if ($urandom_range(1)) send_message($urandom_range(4, 1), 8'd0, 1'b1, 1'b0, 1'b0);
    end

    settle();
    if (mismatch_count == 0 && checks_in_flight == 0) begin
      $display("tb_multi_mode_crc_checksum_top: done, clean");
    end else begin
      $display("tb_multi_mode_crc_checksum_top: done, errors");
    end
    $finish;
  end

endmodule
